### src/periodic_interval_timer_regs_assert.svh
// ----------------------------------------------------------------------------
// Periodic interval timer - assertion macros
// Concurrent checks on clk_i, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_INTERVAL_TIMER_REGS_ASSERT_SVH
`define PERIODIC_INTERVAL_TIMER_REGS_ASSERT_SVH

// check that is off while rst_ni is low
`define PIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that also holds during reset
`define PIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Types, codes and constants of the periodic interval timer.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int unsigned CLOCK_HZ_DEFAULT = 3686400;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned OFF_W  = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SLOT_W = OFF_W - 2;

  // control word mode field
  localparam int unsigned MODE_HI = 11;
  localparam int unsigned MODE_LO = 10;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_READ_WORD  = 3'd1,
    OP_READ_HALF  = 3'd2,
    OP_WRITE_WORD = 3'd3,
    OP_WRITE_HALF = 3'd4
  } pit_op_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_10MS = 2'd1,
    MODE_25MS = 2'd2,
    MODE_1MS  = 2'd3
  } pit_mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_SLOT  = 2'd1,
    FAULT_CDOWN = 2'd2,
    FAULT_HALF  = 2'd3
  } pit_fault_e;

  localparam logic [SLOT_W-1:0] SLOT_CTRL  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_STAT  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_CDOWN = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] NUM_SLOTS  = SLOT_W'(3);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [OFF_W-1:0]  off;
    logic [WORD_W-1:0] val;
  } pit_req_t;

  typedef struct packed {
    logic [1:0]        fault;
    logic              irq;
    logic [WORD_W-1:0] data;
  } pit_rsp_t;

  typedef struct packed {
    logic mode_off;
    logic elapsed_zero;
  } pit_stat_t;

endpackage

### src/pit_in_stage.sv
// ----------------------------------------------------------------------------
// pit_in_stage
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
module pit_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  input  pit_pkg::pit_req_t req_i,
  output logic              vld_o,
  input  logic              adv_i,
  output pit_pkg::pit_req_t req_o
);
  import pit_pkg::*;

  logic     vld_q, vld_d;
  pit_req_t req_q;
  logic     load;

  assign rdy_o = !vld_q || adv_i;
  assign load  = vld_i && rdy_o;
  assign vld_d = load ? 1'b1 : (adv_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign vld_o = vld_q;
  assign req_o = req_q;

endmodule

### src/pit_core.sv
// ----------------------------------------------------------------------------
// pit_core
// Register file, period counter and result register.
// ----------------------------------------------------------------------------
module pit_core #(
  parameter int unsigned ClockHz = pit_pkg::CLOCK_HZ_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  pit_pkg::pit_req_t  req_i,
  output logic               adv_o,
  output logic               vld_o,
  input  logic               rdy_i,
  output pit_pkg::pit_rsp_t  rsp_o,
  output pit_pkg::pit_stat_t stat_o
);
  import pit_pkg::*;

  localparam longint unsigned Per1  = (longint'(ClockHz) * 1)  / 1000;
  localparam longint unsigned Per10 = (longint'(ClockHz) * 10) / 1000;
  localparam longint unsigned Per25 = (longint'(ClockHz) * 25) / 1000;
  localparam int unsigned     PerW  = $clog2(Per25 + 1);

  logic [WORD_W-1:0] ctrl_q, ctrl_d;
  logic              fired_q, fired_d;
  logic [PerW-1:0]   el_q, el_d;
  logic              out_vld_q;
  pit_rsp_t          rsp_q, rsp_d;

  logic              fire;
  logic [1:0]        mode;
  logic [PerW-1:0]   period;
  logic [PerW:0]     el_inc;
  logic [PerW-1:0]   cdown;
  logic [SLOT_W-1:0] slot;
  logic              slot_ok;
  logic [WORD_W-1:0] word;

  assign adv_o = !out_vld_q || rdy_i;
  assign fire  = vld_i && adv_o;

  assign mode = ctrl_q[MODE_HI:MODE_LO];
  always_comb begin
    case (mode)
      MODE_10MS: period = PerW'(Per10);
      MODE_25MS: period = PerW'(Per25);
      MODE_1MS:  period = PerW'(Per1);
      default:   period = '0;
    endcase
  end

  assign el_inc = {1'b0, el_q} + (PerW+1)'(1);
  assign cdown  = (period == '0 || el_q >= period) ? '0 : period - el_q;

  assign slot    = req_i.off[OFF_W-1:2];
  assign slot_ok = slot < NUM_SLOTS;

  always_comb begin
    if (slot == SLOT_CTRL) begin
      word = ctrl_q;
    end else if (slot == SLOT_STAT) begin
      word = {{(WORD_W-1){1'b0}}, fired_q};
    end else begin
      word = WORD_W'(cdown);
    end
  end

  always_comb begin
    ctrl_d  = ctrl_q;
    fired_d = fired_q;
    el_d    = el_q;
    rsp_d.data  = '0;
    rsp_d.fault = FAULT_NONE;
    case (req_i.op)
      OP_TICK: begin
        if (period == '0) begin
          el_d = '0;
        end else if (el_inc >= {1'b0, period}) begin
          el_d    = '0;
          fired_d = 1'b1;
        end else begin
          el_d = el_inc[PerW-1:0];
        end
      end
      OP_READ_WORD: begin
        if (!slot_ok) begin
          rsp_d.fault = FAULT_SLOT;
        end else begin
          rsp_d.data = word;
        end
      end
      OP_READ_HALF: begin
        if (!slot_ok) begin
          rsp_d.fault = FAULT_SLOT;
        end else if (req_i.off[1]) begin
          rsp_d.data = {16'h0, word[31:16]};
        end else begin
          rsp_d.data = {16'h0, word[15:0]};
        end
      end
      OP_WRITE_WORD: begin
        if (!slot_ok) begin
          rsp_d.fault = FAULT_SLOT;
        end else if (slot == SLOT_CTRL) begin
          if (mode != req_i.val[MODE_HI:MODE_LO]) begin
            el_d = '0;
          end
          ctrl_d = req_i.val;
        end else if (slot == SLOT_STAT) begin
          fired_d = fired_q & ~req_i.val[0];
        end else begin
          rsp_d.fault = FAULT_CDOWN;
        end
      end
      OP_WRITE_HALF: rsp_d.fault = FAULT_HALF;
      default: ;
    endcase
    rsp_d.irq = fired_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '0;
      fired_q   <= 1'b0;
      el_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        ctrl_q  <= ctrl_d;
        fired_q <= fired_d;
        el_q    <= el_d;
      end
      if (adv_o) begin
        out_vld_q <= vld_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign vld_o = out_vld_q;
  assign rsp_o = rsp_q;
  assign stat_o.mode_off     = (mode == MODE_OFF);
  assign stat_o.elapsed_zero = (el_q == '0);

endmodule

### src/periodic_interval_timer_regs.sv
// Path: a request passes the input register, then the result register, before its result handshake.
// Throughput: one request per cycle while the result side keeps up; registers and counter update as each is taken.
// A waiting result stalls the input only once the input register is also full.
// Reset (rst_ni low, asynchronous): control word, status, elapsed count and all valid flags cleared.
// ----------------------------------------------------------------------------
// periodic_interval_timer_regs
// Periodic interval timer with control, status and countdown registers.
// ----------------------------------------------------------------------------
module periodic_interval_timer_regs #(
  parameter int unsigned CLOCK_HZ = pit_pkg::CLOCK_HZ_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [7:0] byte_offset, [39:8] write_value
  input  logic [2:0]  s_axis_tuser,  // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] read_data, [32] irq_level, [34:33] fault, rest 0
);
  import pit_pkg::*;

  pit_req_t  s_req;      // request as it arrives
  pit_req_t  core_req;   // request held in the input register
  pit_rsp_t  rsp;
  pit_stat_t stat;
  logic      core_vld;
  logic      core_adv;

  assign s_req.op  = s_axis_tuser;
  assign s_req.off = s_axis_tdata[7:0];
  assign s_req.val = s_axis_tdata[39:8];

  // stage 1: input register, free whenever the core can move on
  pit_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s_axis_tvalid),
    .rdy_o  (s_axis_tready),
    .req_i  (s_req),
    .vld_o  (core_vld),
    .adv_i  (core_adv),
    .req_o  (core_req)
  );

  // stage 2: register update, period count and result register
  pit_core #(
    .ClockHz (CLOCK_HZ)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (core_vld),
    .req_i  (core_req),
    .adv_o  (core_adv),
    .vld_o  (m_axis_tvalid),
    .rdy_i  (m_axis_tready),
    .rsp_o  (rsp),
    .stat_o (stat)
  );

  assign m_axis_tdata = {5'b0, rsp.fault, rsp.irq, rsp.data};

`include "periodic_interval_timer_regs_assert.svh"

  // a faulted request never returns data
  `PIT_ASSERT(a_fault_no_data, (m_axis_tvalid && (m_axis_tdata[34:33] != FAULT_NONE)) |-> (m_axis_tdata[31:0] == 32'h0), "faulted request carries read data")

  // the count sits at zero while the timer is off
  `PIT_ASSERT_ALWAYS(a_off_idle, stat.mode_off |-> stat.elapsed_zero, "elapsed count moves while timer is off")

  // input only stalls when both stages are full
  `PIT_ASSERT(a_stall_full, !s_axis_tready |-> (core_vld && m_axis_tvalid && !m_axis_tready), "input stalled with room in the pipe")

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - periodic interval timer
// Drives ticks and register requests into the timer over the input stream and
// checks every response (read data, interrupt level, fault code) against a
// cycle-free software model of the registers and the period counter.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pit_pkg::*;

  localparam time         CLK_HALF        = 5ns;
  localparam int unsigned RESET_CYCLES    = 4;
  localparam int unsigned CYCLE_LIMIT     = 3_000_000;
  localparam int unsigned RANDOM_REQUESTS = 450;
  localparam int unsigned MAX_IDLE        = 19;
  // a result passes the input and result registers; leave some margin before the final verdict
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam longint unsigned MS_PER_S    = 1000;

  localparam logic [OP_W-1:0]   OP_CODE_MAX  = '1;
  localparam logic [WORD_W-1:0] STATUS_FIRED = WORD_W'(1);

  // byte offsets of the three slots; bit 1 picks the upper half on half reads
  localparam logic [OFF_W-1:0] OFF_CTRL  = {SLOT_CTRL, 2'b00};
  localparam logic [OFF_W-1:0] OFF_STAT  = {SLOT_STAT, 2'b00};
  localparam logic [OFF_W-1:0] OFF_CDOWN = {SLOT_CDOWN, 2'b00};
  localparam logic [OFF_W-1:0] OFF_UPPER = OFF_W'(2);

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [7:0] byte_offset, [39:8] write_value
  logic [2:0]  s_axis_tuser;   // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] read_data, [32] irq_level, [34:33] fault

  // Timer state as the software sees it, updated when a request is accepted.
  logic [WORD_W-1:0] ctrl_q;
  logic [WORD_W-1:0] stat_q;
  int unsigned       elapsed_q;

  pit_rsp_t    expected_responses[$];
  int unsigned mismatches;
  int unsigned random_requests_sent;
  int unsigned cycle_count;
  // cleared during long tick runs so that both sides go at full rate
  bit          idle_enabled;

  periodic_interval_timer_regs i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or drops a response.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles, %0d responses outstanding",
               $realtime, cycle_count, expected_responses.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  function automatic logic [WORD_W-1:0] ctrl_with_mode(input pit_mode_e mode,
                                                       input logic [WORD_W-1:0] other);
    logic [WORD_W-1:0] word;
    word = other;
    word[MODE_HI:MODE_LO] = mode;
    return word;
  endfunction

  // Period length in input ticks; 0 while the timer is off.
  function automatic int unsigned period_ticks(input logic [WORD_W-1:0] ctrl);
    longint unsigned ms;
    case (pit_mode_e'(ctrl[MODE_HI:MODE_LO]))
      MODE_1MS:  ms = 1;
      MODE_10MS: ms = 10;
      MODE_25MS: ms = 25;
      default:   ms = 0;
    endcase
    return 32'(longint'(CLOCK_HZ_DEFAULT) * ms / MS_PER_S);
  endfunction

  function automatic logic [WORD_W-1:0] slot_word(input logic [SLOT_W-1:0] slot);
    int unsigned per;
    per = period_ticks(ctrl_q);
    if (slot == SLOT_CTRL) return ctrl_q;
    if (slot == SLOT_STAT) return stat_q;
    // countdown: ticks left in the current period
    if (per == 0 || elapsed_q >= per) return '0;
    return WORD_W'(per - elapsed_q);
  endfunction

  // Applies one accepted request to the model and queues its response.
  function automatic void predict_timer_response(input logic [OP_W-1:0]   op,
                                                 input logic [OFF_W-1:0]  off,
                                                 input logic [WORD_W-1:0] val);
    pit_rsp_t          rsp;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    int unsigned       per;
    rsp   = '0;
    slot  = off[OFF_W-1:2];
    rsp.fault = FAULT_NONE;
    case (op)
      OP_TICK: begin
        per = period_ticks(ctrl_q);
        if (per == 0) begin
          elapsed_q = 0;
        end else begin
          elapsed_q++;
          if (elapsed_q >= per) begin
            elapsed_q = 0;
            stat_q |= STATUS_FIRED;
          end
        end
      end
      OP_READ_WORD: begin
        if (slot >= NUM_SLOTS) rsp.fault = FAULT_SLOT;
        else rsp.data = slot_word(slot);
      end
      OP_READ_HALF: begin
        if (slot >= NUM_SLOTS) begin
          rsp.fault = FAULT_SLOT;
        end else begin
          word = slot_word(slot);
          rsp.data = (off & OFF_UPPER) != 0 ? {16'h0, word[31:16]} : {16'h0, word[15:0]};
        end
      end
      OP_WRITE_WORD: begin
        if (slot >= NUM_SLOTS) begin
          rsp.fault = FAULT_SLOT;
        end else if (slot == SLOT_CTRL) begin
          // only a change of the mode field restarts the period
          if (ctrl_q[MODE_HI:MODE_LO] != val[MODE_HI:MODE_LO]) elapsed_q = 0;
          ctrl_q = val;
        end else if (slot == SLOT_STAT) begin
          stat_q &= ~val;
        end else begin
          rsp.fault = FAULT_CDOWN;
        end
      end
      OP_WRITE_HALF: rsp.fault = FAULT_HALF;
      default: ;
    endcase
    rsp.irq = stat_q[0];
    expected_responses.push_back(rsp);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    pit_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("response %h with none outstanding", m_axis_tdata));
      end else begin
        want = expected_responses.pop_front();
        if (m_axis_tdata[WORD_W-1:0] !== want.data)
          report_mismatch($sformatf("read_data exp %h got %h",
                                    want.data, m_axis_tdata[WORD_W-1:0]));
        if (m_axis_tdata[WORD_W] !== want.irq)
          report_mismatch($sformatf("irq_level exp %b got %b",
                                    want.irq, m_axis_tdata[WORD_W]));
        if (m_axis_tdata[WORD_W+2:WORD_W+1] !== want.fault)
          report_mismatch($sformatf("fault exp %0d got %0d",
                                    want.fault, m_axis_tdata[WORD_W+2:WORD_W+1]));
        if (m_axis_tdata[39:WORD_W+3] !== '0)
          report_mismatch($sformatf("pad bits not zero: %h", m_axis_tdata[39:WORD_W+3]));
      end
    end
  end

  // Response side: random stall before each response, none while idling is off.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_enabled ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Sends one request; called at a falling edge and returns at one. tvalid is
  // left high so back-to-back requests need no extra edge.
  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [OFF_W-1:0]  off,
                              input logic [WORD_W-1:0] val);
    int unsigned gap;
    gap = idle_enabled ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, off};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_timer_response(op, off, val);
    @(negedge clk_i);
  endtask

  // Ticks with random don't-care fields and an occasional countdown read.
  task automatic run_ticks(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 255) == 0)
        send_request(OP_READ_WORD, OFF_CDOWN | OFF_W'($urandom_range(0, 3)), $urandom());
      send_request(OP_TICK, OFF_W'($urandom()), $urandom());
    end
  endtask

  // Restart in the given mode, run part of the period and read the count back.
  task automatic run_period_part(input pit_mode_e mode, input int unsigned ticks);
    send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_OFF, '0));
    send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(mode, $urandom()));
    send_request(OP_WRITE_WORD, OFF_STAT, '1);
    send_request(OP_READ_HALF, OFF_CDOWN | OFF_UPPER, '0);
    run_ticks(ticks);
    send_request(OP_READ_WORD, OFF_CDOWN, '0);
    send_request(OP_READ_HALF, OFF_CDOWN, '0);
    send_request(OP_READ_WORD, OFF_STAT, '0);
  endtask

  task automatic send_random_request();
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [OFF_W-1:0]  off;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_TICK;
    else if (pick < 50) op = OP_READ_WORD;
    else if (pick < 65) op = OP_READ_HALF;
    else if (pick < 90) op = OP_WRITE_WORD;
    else if (pick < 95) op = OP_WRITE_HALF;
    else                op = OP_W'($urandom_range(OP_WRITE_HALF + 1, OP_CODE_MAX));
    // mostly the three slots, sometimes anywhere in the byte range
    if ($urandom_range(0, 99) < 85) off = OFF_W'($urandom_range(0, 4 * NUM_SLOTS - 1));
    else                            off = OFF_W'($urandom());
    send_request(op, off, $urandom());
    random_requests_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_reset_values();
    send_request(OP_READ_WORD, OFF_CTRL, '0);
    send_request(OP_READ_WORD, OFF_STAT, '0);
    send_request(OP_READ_WORD, OFF_CDOWN, '0);
  endtask

  // Alignment, half reads, faults and unknown codes, all with the timer off.
  task automatic test_register_access();
    send_request(OP_WRITE_WORD, OFF_CTRL | OFF_W'(3), ctrl_with_mode(MODE_OFF, '1));
    send_request(OP_READ_WORD, OFF_CTRL | OFF_W'(1), '1);
    send_request(OP_READ_HALF, OFF_CTRL, '0);
    send_request(OP_READ_HALF, OFF_CTRL | OFF_UPPER | OFF_W'(1), '0);
    send_request(OP_TICK, '1, '1);
    send_request(OP_READ_WORD, OFF_CDOWN, '0);
    send_request(OP_WRITE_WORD, OFF_CDOWN, '1);
    send_request(OP_WRITE_HALF, OFF_CTRL, '1);
    send_request(OP_WRITE_HALF, '1, '0);
    send_request(OP_READ_WORD, {NUM_SLOTS, 2'b00}, '0);
    send_request(OP_READ_WORD, '1, '0);
    send_request(OP_READ_HALF, '1, '0);
    send_request(OP_WRITE_WORD, {1'b1, {(OFF_W-1){1'b0}}}, '1);
    send_request(OP_W'(OP_WRITE_HALF + 1), '1, '1);
    send_request(OP_CODE_MAX, '0, '1);
    send_request(OP_WRITE_WORD, OFF_STAT, '1);
    send_request(OP_WRITE_WORD, OFF_CTRL, '0);
  endtask

  // Only a new mode field restarts the period.
  task automatic test_mode_change();
    send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_1MS, 32'h5A5A_5A5A));
    repeat (3) send_request(OP_TICK, '0, '0);
    send_request(OP_READ_WORD, OFF_CDOWN, '0);
    send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_1MS, 32'hA5A5_A5A5));
    send_request(OP_READ_HALF, OFF_CDOWN, '0);
    send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_10MS, '0));
    send_request(OP_READ_HALF, OFF_CDOWN | OFF_UPPER, '0);
    send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_25MS, '0));
    send_request(OP_TICK, '0, '0);
    send_request(OP_READ_WORD, OFF_CDOWN, '0);
    send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_OFF, '0));
    send_request(OP_READ_WORD, OFF_CDOWN, '0);
  endtask

  // Elapsed count in 1 ms mode, then status writes.
  task automatic test_count_and_status();
    idle_enabled = 1'b0;
    run_period_part(MODE_1MS, 150 + $urandom_range(0, 50));
    idle_enabled = 1'b1;
    send_request(OP_READ_WORD, OFF_STAT, '0);
    send_request(OP_WRITE_WORD, OFF_STAT, ~STATUS_FIRED);
    send_request(OP_READ_WORD, OFF_STAT, '0);
    send_request(OP_WRITE_WORD, OFF_STAT, STATUS_FIRED);
    send_request(OP_READ_HALF, OFF_STAT, '0);
  endtask

  // The two long periods; the 25 ms countdown has bit 16 set in its upper half.
  task automatic test_long_periods();
    idle_enabled = 1'b0;
    run_period_part(MODE_10MS, 120);
    run_period_part(MODE_25MS, 120);
    idle_enabled = 1'b1;
  endtask

  // Bursts of mixed requests, short 1 ms tick runs, and ticks while off.
  task automatic test_random();
    int unsigned kind;
    while (random_requests_sent < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 9);
      idle_enabled = ($urandom_range(0, 3) != 0);
      if (kind < 7) begin
        repeat ($urandom_range(1, 30)) send_random_request();
      end else if (kind < 9) begin
        idle_enabled = 1'b0;
        send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_1MS, $urandom()));
        run_ticks($urandom_range(1, 60));
        send_request(OP_READ_WORD, OFF_STAT, '0);
      end else begin
        send_request(OP_WRITE_WORD, OFF_CTRL, ctrl_with_mode(MODE_OFF, $urandom()));
        run_ticks($urandom_range(1, 20));
        send_request(OP_READ_WORD, OFF_CDOWN, '0);
      end
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    ctrl_q        = '0;
    stat_q        = '0;
    elapsed_q     = 0;
    mismatches    = 0;
    cycle_count   = 0;
    random_requests_sent = 0;
    idle_enabled  = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_register_access();
    test_mode_change();
    test_count_and_status();
    test_long_periods();
    test_random();

    s_axis_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    // catch any stray response after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### periodic_interval_timer_regs.f
+incdir+src
src/pit_pkg.sv
src/pit_in_stage.sv
src/pit_core.sv
src/periodic_interval_timer_regs.sv
sim/testbench.sv
